// File: sv/assert_macros.svh
// Assertion macros shared by the ledger RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: sv/rtl_pkg.sv
// Types and constants of the token ledger
package rtl_pkg;
    localparam logic [31:0] SEAL_MULT  = 32'hDEADBEEF;
    localparam logic [63:0] SEAL_SALT  = 64'h0000_0053_5953_4F53;
    localparam int          SEAL_SHIFT = 40;

    typedef enum logic [1:0] {
        CMD_MINT     = 2'd0,
        CMD_SPEND    = 2'd1,
        CMD_DELEGATE = 2'd2,
        CMD_SWEEP    = 2'd3
    } t_cmd;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FULL        = 3'd1;
    localparam logic [2:0] ST_BAD_ID      = 3'd2;
    localparam logic [2:0] ST_NOT_OWNER   = 3'd3;
    localparam logic [2:0] ST_SPENT       = 3'd4;
    localparam logic [2:0] ST_SHORT       = 3'd5;
    localparam logic [2:0] ST_BAD_SEAL    = 3'd6;
    localparam logic [2:0] ST_NO_TRANSFER = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHECK, S_WB, S_MUL2, S_APPEND, S_SWEEP, S_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] owner;
        logic [7:0]  kind;
        logic [63:0] balance;
        logic [63:0] expiry;
        logic        xfer;
        logic [63:0] seal;
        logic        used;
    } t_entry;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic mul_rcp;
        logic rd_en;
        logic do_check;
        logic do_wb;
        logic do_append;
        logic sweep_step;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic check_ok;
        logic sweep_done;
        logic out_free;
    } t_ctl_stat;
endpackage

// File: sv/rtl_ctrl.sv
// Command sequencer of the token ledger
module rtl_ctrl
    import rtl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_MUL;
            S_MUL: begin
                unique case (i_stat.cmd)
                    CMD_MINT:  n_state = S_APPEND;
                    CMD_SWEEP: n_state = S_SWEEP;
                    default:   n_state = S_CHECK;
                endcase
            end
            S_CHECK:  n_state = S_WB;
            S_WB: begin
                if (!i_stat.check_ok || i_stat.cmd == CMD_SPEND) n_state = S_DONE;
                else n_state = S_MUL2;
            end
            S_MUL2:   n_state = S_APPEND;
            S_APPEND: n_state = S_DONE;
            S_SWEEP:  if (i_stat.sweep_done) n_state = S_DONE;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            S_MUL:    o_cmd.rd_en = 1'b1;
            S_CHECK:  o_cmd.do_check = 1'b1;
            S_WB:     o_cmd.do_wb = 1'b1;
            S_MUL2:   o_cmd.mul_rcp = 1'b1;
            S_APPEND: o_cmd.do_append = 1'b1;
            S_SWEEP:  o_cmd.sweep_step = 1'b1;
            S_DONE:   o_cmd.out_load = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end
endmodule

// File: sv/rtl_dpath.sv
// Entry memory, seal multiplier, checks and result register of the ledger
module rtl_dpath
    import rtl_pkg::*;
#(
    parameter int TABLE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl_cmd    i_cmd,
    output t_ctl_stat   o_stat,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_requester_pid,
    input  logic [9:0]  i_token_index,
    input  logic [31:0] i_recipient_pid,
    input  logic [63:0] i_quantity,
    input  logic [7:0]  i_kind,
    input  logic [63:0] i_expiry_time,
    input  logic        i_may_transfer,
    input  logic [63:0] i_current_time,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [2:0]  o_status,
    output logic [8:0]  o_issued_id,
    output logic [9:0]  o_expired_count
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > 10) ? CW : 10;

    t_entry      r_mem [TABLE_DEPTH];
    t_entry      r_rd;
    t_cmd        r_command;
    logic [31:0] r_req, r_rcp;
    logic [9:0]  r_idx;
    logic [63:0] r_qty, r_exp, r_now, r_prod, r_nb;
    logic [7:0]  r_kind;
    logic        r_xfer, r_ok, r_out_valid, r_pv;
    logic [2:0]  r_status;
    logic [AW-1:0] r_id, r_paddr;
    logic [CW-1:0] r_count, r_ptr, r_expired;

    logic [31:0] mul_a;
    logic        bad_id, full, ptr_live, due;
    logic        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    t_entry      wr_data;
    logic [2:0]  chk_status;

    assign mul_a    = i_cmd.mul_rcp ? r_rcp : r_req;
    assign bad_id   = IW'(r_idx) >= IW'(r_count);
    assign full     = r_count >= CW'(TABLE_DEPTH);
    assign ptr_live = r_ptr < r_count;
    assign due      = !r_rd.used && (r_rd.expiry != 64'd0) && (r_now >= r_rd.expiry);
    assign rd_addr  = i_cmd.sweep_step ? AW'(r_ptr) : AW'(r_idx);

    always_comb begin
        chk_status = ST_OK;
        if (bad_id) begin
            chk_status = ST_BAD_ID;
        end else if (r_rd.owner != r_req) begin
            chk_status = ST_NOT_OWNER;
        end else if (r_command == CMD_SPEND) begin
            if (r_rd.used) chk_status = ST_SPENT;
            else if (r_rd.balance < r_qty) chk_status = ST_SHORT;
            else if (r_rd.seal != (r_prod ^ (64'(r_rd.kind) << SEAL_SHIFT)
                                   ^ r_rd.balance ^ SEAL_SALT))
                chk_status = ST_BAD_SEAL;
        end else begin
            if (!r_rd.xfer) chk_status = ST_NO_TRANSFER;
            else if (r_rd.balance < r_qty) chk_status = ST_SHORT;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(r_idx);
        wr_data = r_rd;
        if (i_cmd.do_wb) begin
            wr_en = r_ok;
            wr_data.balance = r_nb;
            wr_data.seal = r_prod ^ (64'(r_rd.kind) << SEAL_SHIFT) ^ r_nb ^ SEAL_SALT;
            wr_data.used = r_rd.used || (r_command == CMD_SPEND && r_nb == 64'd0);
        end else if (i_cmd.do_append) begin
            wr_en   = !full;
            wr_addr = AW'(r_count);
            wr_data.owner   = (r_command == CMD_MINT) ? r_req : r_rcp;
            wr_data.kind    = (r_command == CMD_MINT) ? r_kind : r_rd.kind;
            wr_data.balance = r_qty;
            wr_data.expiry  = (r_command == CMD_MINT) ? r_exp : r_rd.expiry;
            wr_data.xfer    = (r_command == CMD_MINT) ? r_xfer : 1'b0;
            wr_data.seal    = r_prod ^ (64'(wr_data.kind) << SEAL_SHIFT)
                              ^ r_qty ^ SEAL_SALT;
            wr_data.used    = 1'b0;
        end else if (i_cmd.sweep_step) begin
            wr_en   = r_pv && due;
            wr_addr = r_paddr;
            wr_data.used = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en || (i_cmd.sweep_step && ptr_live)) r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, mul_a} * {32'd0, SEAL_MULT};
        if (i_cmd.capture) begin
            r_command <= t_cmd'(i_command);
            r_req  <= i_requester_pid;
            r_idx  <= i_token_index;
            r_rcp  <= i_recipient_pid;
            r_qty  <= i_quantity;
            r_kind <= i_kind;
            r_exp  <= i_expiry_time;
            r_xfer <= i_may_transfer;
            r_now  <= i_current_time;
            r_id   <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.do_check) begin
            r_status <= chk_status;
            r_ok     <= chk_status == ST_OK;
            r_nb     <= r_rd.balance - r_qty;
        end
        if (i_cmd.do_append) begin
            if (full) r_status <= ST_FULL;
            else r_id <= AW'(r_count);
        end
        if (i_cmd.sweep_step && ptr_live) r_paddr <= AW'(r_ptr);
        if (i_cmd.out_load) begin
            o_status        <= r_status;
            o_issued_id     <= 9'(r_id);
            o_expired_count <= 10'(r_expired);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ptr       <= '0;
            r_expired   <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_append && !full) r_count <= r_count + CW'(1);
            if (i_cmd.capture) begin
                r_ptr     <= '0;
                r_expired <= '0;
                r_pv      <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                r_pv <= ptr_live;
                if (ptr_live) r_ptr <= r_ptr + CW'(1);
                if (r_pv && due) r_expired <= r_expired + CW'(1);
            end
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.cmd        = r_command;
    assign o_stat.check_ok   = r_ok;
    assign o_stat.sweep_done = !ptr_live && !r_pv;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
endmodule

// File: sv/resource_token_ledger.sv
// Token ledger, one beat at a time. Mint: S_MUL, S_APPEND, S_DONE. Spend: S_MUL,
// S_CHECK, S_WB, S_DONE. Delegate: S_MUL, S_CHECK, S_WB, S_MUL2, S_APPEND, S_DONE
// (a failed check goes from S_WB to S_DONE). Sweep: S_MUL, S_SWEEP, S_DONE. The
// result is registered in S_DONE; a stalled result holds the next beat off until
// it is taken. Sweep length is set by the single read port of the entry memory.
// Synchronous active-low reset empties the table; entries need no clearing.
`include "assert_macros.svh"
module resource_token_ledger
    import rtl_pkg::*;
#(
    parameter int TABLE_DEPTH = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_requester_pid,
    input  logic [9:0]  i_token_index,
    input  logic [31:0] i_recipient_pid,
    input  logic [63:0] i_quantity,
    input  logic [7:0]  i_kind,
    input  logic [63:0] i_expiry_time,
    input  logic        i_may_transfer,
    input  logic [63:0] i_current_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [8:0]  o_issued_id,
    output logic [9:0]  o_expired_count
);
    t_ctl_cmd  ctl_cmd;
    t_ctl_stat ctl_stat;

    rtl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (ctl_stat),
        .o_cmd      (ctl_cmd)
    );

    rtl_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_stat          (ctl_stat),
        .i_command       (i_command),
        .i_requester_pid (i_requester_pid),
        .i_token_index   (i_token_index),
        .i_recipient_pid (i_recipient_pid),
        .i_quantity      (i_quantity),
        .i_kind          (i_kind),
        .i_expiry_time   (i_expiry_time),
        .i_may_transfer  (i_may_transfer),
        .i_current_time  (i_current_time),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_issued_id     (o_issued_id),
        .o_expired_count (o_expired_count)
    );

    assign o_in_stall = !ctl_cmd.in_ready;

    `ASSERT_PROP(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `ASSERT_NEVER(a_id_only_on_ok, i_clk, i_rst_n, o_out_valid && o_status != ST_OK && o_issued_id != 9'd0)
    `ASSERT_NEVER(a_count_only_on_ok, i_clk, i_rst_n, o_out_valid && o_expired_count != 10'd0 && o_status != ST_OK)
endmodule

// File: tb/sv/resource_token_ledger_test.sv
// Self-checking testbench for the token ledger: table predictor, directed and random ledger traffic
`timescale 1ns / 100ps
module resource_token_ledger_test
    import rtl_pkg::*;
();

    localparam int DEPTH       = 512;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 600;

    typedef struct {
        logic [2:0] status;
        logic [8:0] issued;
        logic [9:0] expired;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [31:0] i_requester_pid;
    logic [9:0]  i_token_index;
    logic [31:0] i_recipient_pid;
    logic [63:0] i_quantity;
    logic [7:0]  i_kind;
    logic [63:0] i_expiry_time;
    logic        i_may_transfer;
    logic [63:0] i_current_time;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [8:0]  o_issued_id;
    logic [9:0]  o_expired_count;

    // ledger copy
    int          ledger_count;
    logic [31:0] ledger_owner [DEPTH];
    logic [7:0]  ledger_kind [DEPTH];
    logic [63:0] ledger_balance [DEPTH];
    logic [63:0] ledger_expiry [DEPTH];
    logic        ledger_xfer [DEPTH];
    logic [63:0] ledger_seal [DEPTH];
    logic        ledger_used [DEPTH];

    t_answer pending_answers[$];
    int      mismatches;
    int      send_idle_pct;
    int      stall_pct;
    int      hold_off;
    longint  cycles;

    resource_token_ledger DUT (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] seal_value(logic [31:0] owner, logic [7:0] kind,
                                               logic [63:0] bal);
        return ({32'd0, owner} * {32'd0, SEAL_MULT}) ^ ({56'd0, kind} << SEAL_SHIFT)
               ^ bal ^ SEAL_SALT;
    endfunction

    function automatic bit ledger_append(logic [31:0] owner, logic [7:0] kind,
                                         logic [63:0] bal, logic [63:0] expiry,
                                         logic xfer, output int id);
        id = ledger_count;
        if (ledger_count >= DEPTH) return 0;
        ledger_owner[id]   = owner;
        ledger_kind[id]    = kind;
        ledger_balance[id] = bal;
        ledger_expiry[id]  = expiry;
        ledger_xfer[id]    = xfer;
        ledger_seal[id]    = seal_value(owner, kind, bal);
        ledger_used[id]    = 1'b0;
        ledger_count++;
        return 1;
    endfunction

    function automatic t_answer ledger_apply(t_cmd cmd, logic [31:0] req, logic [9:0] idx,
                                             logic [31:0] rcp, logic [63:0] qty,
                                             logic [7:0] kind, logic [63:0] expiry,
                                             logic xfer, logic [63:0] now);
        t_answer     a;
        int          id;
        int          n;
        logic [63:0] nb;
        a.status  = ST_OK;
        a.issued  = '0;
        a.expired = '0;
        n = 0;
        case (cmd)
            CMD_MINT: begin
                if (ledger_append(req, kind, qty, expiry, xfer, id)) a.issued = id[8:0];
                else a.status = ST_FULL;
            end
            CMD_SPEND: begin
                if (idx >= ledger_count) a.status = ST_BAD_ID;
                else if (ledger_owner[idx] != req) a.status = ST_NOT_OWNER;
                else if (ledger_used[idx]) a.status = ST_SPENT;
                else if (ledger_balance[idx] < qty) a.status = ST_SHORT;
                else if (ledger_seal[idx] != seal_value(req, ledger_kind[idx],
                                                        ledger_balance[idx]))
                    a.status = ST_BAD_SEAL;
                else begin
                    nb = ledger_balance[idx] - qty;
                    ledger_balance[idx] = nb;
                    ledger_seal[idx] = seal_value(ledger_owner[idx], ledger_kind[idx], nb);
                    if (nb == 0) ledger_used[idx] = 1'b1;
                end
            end
            CMD_DELEGATE: begin
                if (idx >= ledger_count) a.status = ST_BAD_ID;
                else if (ledger_owner[idx] != req) a.status = ST_NOT_OWNER;
                else if (!ledger_xfer[idx]) a.status = ST_NO_TRANSFER;
                else if (ledger_balance[idx] < qty) a.status = ST_SHORT;
                else begin
                    nb = ledger_balance[idx] - qty;
                    ledger_balance[idx] = nb;
                    ledger_seal[idx] = seal_value(ledger_owner[idx], ledger_kind[idx], nb);
                    if (ledger_append(rcp, ledger_kind[idx], qty, ledger_expiry[idx], 1'b0, id))
                        a.issued = id[8:0];
                    else a.status = ST_FULL;
                end
            end
            default: begin
                for (int i = 0; i < ledger_count; i++) begin
                    if (!ledger_used[i] && ledger_expiry[i] != 0 && now >= ledger_expiry[i]) begin
                        ledger_used[i] = 1'b1;
                        n++;
                    end
                end
                a.expired = n[9:0];
            end
        endcase
        return a;
    endfunction

    task automatic send_beat(t_cmd cmd, logic [31:0] req, logic [9:0] idx, logic [31:0] rcp,
                             logic [63:0] qty, logic [7:0] kind, logic [63:0] expiry,
                             logic xfer, logic [63:0] now);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_requester_pid <= req;
        i_token_index   <= idx;
        i_recipient_pid <= rcp;
        i_quantity      <= qty;
        i_kind          <= kind;
        i_expiry_time   <= expiry;
        i_may_transfer  <= xfer;
        i_current_time  <= now;
        do @(posedge i_clk); while (o_in_stall);
        pending_answers.push_back(ledger_apply(cmd, req, idx, rcp, qty, kind, expiry, xfer,
                                               now));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_amount(logic [63:0] bal);
        case ($urandom_range(9))
            0: return bal;
            1: return bal + 1;
            2: return {$urandom, $urandom};
            default: return (bal == 0) ? 64'd0
                                       : $urandom_range(0, (bal > 64'd2000) ? 32'd2000
                                                                            : 32'(bal));
        endcase
    endfunction

    function automatic logic [63:0] pick_expiry();
        case ($urandom_range(9))
            0, 1, 2: return 64'd0;
            3: return {$urandom, $urandom};
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    task automatic send_random_beat(int mint_pct);
        int          r;
        int          idx;
        logic [31:0] req;
        r = $urandom_range(99);
        if (ledger_count == 0 || r < mint_pct) begin
            send_beat(CMD_MINT, $urandom, 10'($urandom), $urandom,
                      ($urandom_range(7) == 0) ? {$urandom, $urandom} : $urandom_range(1, 3000),
                      8'($urandom), pick_expiry(), $urandom_range(3) != 0,
                      {$urandom, $urandom});
        end else if (r < 92) begin
            idx = ($urandom_range(9) == 0) ? $urandom_range(0, 1023)
                                           : $urandom_range(0, ledger_count - 1);
            req = (idx < ledger_count && $urandom_range(9) != 0) ? ledger_owner[idx] : $urandom;
            send_beat((r & 1) ? CMD_SPEND : CMD_DELEGATE, req, idx[9:0], $urandom,
                      pick_amount(idx < ledger_count ? ledger_balance[idx] : 64'd100),
                      8'($urandom), {$urandom, $urandom}, 1'($urandom), {$urandom, $urandom});
        end else begin
            send_beat(CMD_SWEEP, $urandom, 10'($urandom), $urandom, {$urandom, $urandom},
                      8'($urandom), {$urandom, $urandom}, 1'($urandom),
                      ($urandom_range(9) == 0) ? '1 : $urandom_range(0, 3000));
        end
    endtask

    task automatic test_directed();
        int base;
        send_idle_pct = 0;
        stall_pct = 0;
        base = ledger_count;
        send_beat(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, '1);
        send_beat(CMD_SPEND, 0, 0, 0, 0, 0, 0, 0, 0);
        send_beat(CMD_MINT, '1, '1, '1, '1, '1, '1, 1'b1, '1);
        send_beat(CMD_MINT, 32'h1234, 0, 0, 0, 8'h01, 0, 1'b0, 0);
        send_beat(CMD_MINT, 32'h55, 0, 0, 100, 8'h02, 64'd50, 1'b1, 0);
        send_beat(CMD_MINT, 32'h66, 0, 0, 40, 8'h04, 0, 1'b1, 0);
        send_beat(CMD_SPEND, 32'h55, 10'h3FF, 0, 1, 0, 0, 0, 0);
        send_beat(CMD_SPEND, 32'h56, 10'(base + 2), 0, 1, 0, 0, 0, 0);
        send_beat(CMD_SPEND, 32'h55, 10'(base + 2), 0, 101, 0, 0, 0, 0);
        send_beat(CMD_SPEND, 32'h55, 10'(base + 2), 0, 30, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h1234, 10'(base + 1), 32'h77, 0, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h55, 10'(base + 2), 32'h77, 20, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h66, 10'(base + 3), 32'h88, 40, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h66, 10'(base + 3), 32'h88, 1, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h65, 10'(base + 3), 32'h88, 0, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h66, 10'h3FF, 32'h88, 0, 0, 0, 0, 0);
        send_beat(CMD_SPEND, 32'h55, 10'(base + 2), 0, 50, 0, 0, 0, 0);
        send_beat(CMD_SPEND, 32'h55, 10'(base + 2), 0, 0, 0, 0, 0, 0);
        send_beat(CMD_DELEGATE, 32'h55, 10'(base + 2), 32'h99, 0, 0, 0, 0, 0);
        send_beat(CMD_SPEND, '1, 10'(base), 0, 64'd5, 0, 0, 0, 0);
        send_beat(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, 64'd49);
        send_beat(CMD_SWEEP, 0, 0, 0, 0, 0, 0, 0, '1);
        drain_results();
    endtask

    task automatic test_random(int beats, int sidle, int rstall);
        send_idle_pct = sidle;
        stall_pct = rstall;
        repeat (beats) send_random_beat(35);
        drain_results();
    endtask

    task automatic test_pressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 300;
        repeat (10) send_random_beat(50);
        drain_results();
    endtask

    task automatic test_fill();
        int src;
        send_idle_pct = 22;
        stall_pct = 22;
        while (ledger_count < DEPTH) send_random_beat(95);
        send_beat(CMD_MINT, $urandom, 0, 0, 5, 8'($urandom), 0, 1'b1, 0);
        src = -1;
        for (int i = 0; i < DEPTH; i++)
            if (src < 0 && ledger_xfer[i]) src = i;
        if (src >= 0)
            send_beat(CMD_DELEGATE, ledger_owner[src], 10'(src), $urandom,
                      ledger_balance[src] >> 1, 0, 0, 0, 0);
        repeat (20) send_random_beat(20);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: status %0d", o_status);
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status || o_issued_id !== want.issued
                    || o_expired_count !== want.expired) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d issued %0d/%0d expired %0d/%0d",
                                 want.status, o_status, want.issued, o_issued_id,
                                 want.expired, o_expired_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        cycles          = 0;
        mismatches      = 0;
        hold_off        = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        ledger_count    = 0;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_out_stall     = 1'b0;
        i_command       = CMD_MINT;
        i_requester_pid = '0;
        i_token_index   = '0;
        i_recipient_pid = '0;
        i_quantity      = '0;
        i_kind          = '0;
        i_expiry_time   = '0;
        i_may_transfer  = 1'b0;
        i_current_time  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(40, 0, 0);
        test_random(40, 78, 0);
        test_random(40, 0, 78);
        test_random(40, 22, 22);
        test_pressure();
        test_fill();
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
